// ===== src/b62_pkg.sv =====
// Package for the base-62 number encoder.
// Holds widths, sequencer state type and the digit-to-ASCII mapping.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b62_pkg;

  localparam int unsigned ValueW   = 64;
  localparam int unsigned DigitW   = 6;
  localparam int unsigned CharW    = 7;
  localparam int unsigned MaxDigits = 11;
  localparam int unsigned CountW   = 4;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned BytesPerValue = ValueW / ByteW;
  localparam int unsigned ByteCntW = $clog2(BytesPerValue);
  localparam logic [DigitW-1:0] Radix = 6'd62;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  function automatic logic [CharW-1:0] glyph(input logic [DigitW-1:0] d);
    logic [CharW-1:0] c;
    if (d < 6'd10) begin
      c = 7'd48 + {1'b0, d};
    end else if (d < 6'd36) begin
      c = 7'd87 + {1'b0, d};
    end else if (d < Radix) begin
      c = 7'd29 + {1'b0, d};
    end else begin
      c = 7'd48;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/b62_div_step.sv =====
// Shared divide unit: one byte of long division by 62 per use.
// Takes the running remainder and the next byte, gives the quotient byte.
// Depends on b62_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b62_div_step (
  input  wire logic [b62_pkg::DigitW-1:0] rem_in,
  input  wire logic [b62_pkg::ByteW-1:0]  byte_in,
  output logic      [b62_pkg::DigitW-1:0] rem_out,
  output logic      [b62_pkg::ByteW-1:0]  quo_byte
);

  always_comb begin
    logic [b62_pkg::DigitW:0] r;
    r = {1'b0, rem_in};
    quo_byte = '0;
    for (int i = b62_pkg::ByteW - 1; i >= 0; i--) begin
      r = {r[b62_pkg::DigitW-1:0], byte_in[i]};
      if (r >= {1'b0, b62_pkg::Radix}) begin
        r = r - {1'b0, b62_pkg::Radix};
        quo_byte[i] = 1'b1;
      end
    end
    rem_out = r[b62_pkg::DigitW-1:0];
  end

endmodule

`default_nettype wire

// ===== src/base62_number_encoder_core.sv =====
// Top level of the base-62 number encoder: sequencer, digit store, output register.
// Depends on b62_pkg and b62_div_step.
//
//  channel  | ports                  | handshake
//  ---------+------------------------+------------------------------------
//  input    | value                  | transfer when start & !busy
//  result   | char_code, is_last     | transfer on each strobe cycle
//
// Each digit comes from long division by 62: the shared divide unit consumes
// one byte of the quotient per cycle. A number of n digits (1..11) is divided
// digit by digit, then emitted most significant first, one character per cycle.
// The last character's strobe comes in the first cycle with busy low.
// rst is synchronous and clears the sequencer and strobe.
// The receiver cannot stall; characters are never held back.
`timescale 1ns / 1ps
`default_nettype none

module base62_number_encoder_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [b62_pkg::ValueW-1:0]   value,
  output logic                              strobe,
  output logic      [b62_pkg::CharW-1:0]    char_code,
  output logic                              is_last
);

  b62_pkg::state_t state;
  logic [b62_pkg::ValueW-1:0]   quo;
  logic [b62_pkg::DigitW-1:0]   rem;
  logic [b62_pkg::ByteCntW-1:0] byte_cnt;
  logic [b62_pkg::CountW-1:0]   digit_count;
  logic [b62_pkg::CountW-1:0]   emit_idx;
  logic [b62_pkg::DigitW-1:0]   digits [b62_pkg::MaxDigits];

  logic [b62_pkg::DigitW-1:0] rem_next;
  logic [b62_pkg::ByteW-1:0]  quo_byte;
  logic [b62_pkg::ValueW-1:0] quo_next;

  b62_div_step u_div (
    .rem_in  (rem),
    .byte_in (quo[b62_pkg::ValueW-1 -: b62_pkg::ByteW]),
    .rem_out (rem_next),
    .quo_byte(quo_byte)
  );

  assign quo_next = {quo[b62_pkg::ValueW-b62_pkg::ByteW-1:0], quo_byte};
  assign busy = (state != b62_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= b62_pkg::ST_IDLE;
      strobe      <= 1'b0;
      digit_count <= '0;
      byte_cnt    <= '0;
      emit_idx    <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        b62_pkg::ST_IDLE: begin
          if (start) begin
            quo         <= value;
            rem         <= '0;
            byte_cnt    <= '0;
            digit_count <= '0;
            state       <= b62_pkg::ST_DIV;
          end
        end
        b62_pkg::ST_DIV: begin
          quo      <= quo_next;
          byte_cnt <= byte_cnt + 1'b1;
          if (byte_cnt == b62_pkg::ByteCntW'(b62_pkg::BytesPerValue - 1)) begin
            digits[digit_count] <= rem_next;
            digit_count         <= digit_count + 1'b1;
            rem                 <= '0;
            if (quo_next == '0 ||
                digit_count == b62_pkg::CountW'(b62_pkg::MaxDigits - 1)) begin
              emit_idx <= digit_count;
              state    <= b62_pkg::ST_EMIT;
            end
          end else begin
            rem <= rem_next;
          end
        end
        b62_pkg::ST_EMIT: begin
          char_code <= b62_pkg::glyph(digits[emit_idx]);
          is_last   <= (emit_idx == '0);
          strobe    <= 1'b1;
          if (emit_idx == '0) begin
            state <= b62_pkg::ST_IDLE;
          end else begin
            emit_idx <= emit_idx - 1'b1;
          end
        end
        default: begin
          state <= b62_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_base62_number_encoder_core.sv =====
// Testbench for base62_number_encoder_core: drives 64-bit values, predicts the
// base-62 character run of each and checks every strobed character in order.
// Depends on b62_pkg and the encoder RTL.
`timescale 1ns / 1ps

module tb_base62_number_encoder_core;

  localparam logic [b62_pkg::ValueW-1:0] BASE = 64'd62;
  localparam int unsigned       CYCLE_LIMIT = 500000;
  localparam int unsigned       DRAIN_WAIT  = 120;
  localparam int unsigned       RANDOM_ITEMS = 350;

  typedef struct packed {
    logic [b62_pkg::CharW-1:0] code;
    logic                      last;
  } char_t;

  class char_scoreboard;
    char_t       pending[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function logic [b62_pkg::CharW-1:0] digit_ascii(input logic [b62_pkg::DigitW-1:0] d);
      logic [b62_pkg::CharW-1:0] c;
      if (d < 10) begin
        c = b62_pkg::CharW'(48 + int'(d));
      end else if (d < 36) begin
        c = b62_pkg::CharW'(97 + int'(d) - 10);
      end else begin
        c = b62_pkg::CharW'(65 + int'(d) - 36);
      end
      return c;
    endfunction

    // Split the value into base-62 digits, least significant first, then queue
    // the characters most significant first.
    function void note_value(input logic [b62_pkg::ValueW-1:0] v);
      logic [b62_pkg::ValueW-1:0] q;
      logic [b62_pkg::DigitW-1:0] digits [0:b62_pkg::MaxDigits-1];
      int                         n;
      char_t                      e;
      q = v;
      n = 0;
      do begin
        digits[n] = b62_pkg::DigitW'(q % BASE);
        q = q / BASE;
        n++;
      end while (q != 0);
      for (int k = n - 1; k >= 0; k--) begin
        e.code = digit_ascii(digits[k]);
        e.last = (k == 0);
        pending.push_back(e);
      end
    endfunction

    function void report(input string what, input char_t exp_c, input char_t got_c);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s: expected char %h last %0b, got char %h last %0b",
                 $realtime, what, exp_c.code, exp_c.last, got_c.code, got_c.last);
      end
    endfunction

    function void check_char(input logic [b62_pkg::CharW-1:0] code, input logic last);
      char_t got_c;
      char_t exp_c;
      got_c.code = code;
      got_c.last = last;
      if (pending.size() == 0) begin
        exp_c = '0;
        report("unexpected character", exp_c, got_c);
      end else begin
        exp_c = pending.pop_front();
        if (exp_c.code !== got_c.code || exp_c.last !== got_c.last) begin
          report("character mismatch", exp_c, got_c);
        end
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic [b62_pkg::ValueW-1:0]   value;
  logic                         strobe;
  logic [b62_pkg::CharW-1:0]    char_code;
  logic                         is_last;
  int unsigned                  cycles;
  char_scoreboard               sb;

  base62_number_encoder_core u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .strobe    (strobe),
    .char_code (char_code),
    .is_last   (is_last)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && strobe) begin
      sb.check_char(char_code, is_last);
    end
  end

  function automatic logic [b62_pkg::ValueW-1:0] pow62(input int k);
    logic [b62_pkg::ValueW-1:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++) begin
      p = p * BASE;
    end
    return p;
  endfunction

  function automatic logic [b62_pkg::ValueW-1:0] random_value();
    logic [b62_pkg::ValueW-1:0] full;
    int unsigned                pick;
    full = {$urandom(), $urandom()};
    pick = $urandom_range(99);
    if (pick < 40) begin
      return full;
    end else if (pick < 80) begin
      return full >> (b62_pkg::ValueW - $urandom_range(1, b62_pkg::ValueW));
    end else if (pick < 90) begin
      return b62_pkg::ValueW'($urandom_range(0, 4000));
    end else begin
      return pow62($urandom_range(1, 10)) + b62_pkg::ValueW'($urandom_range(0, 4)) - 64'd2;
    end
  endfunction

  // Unless calm, hold start low for random idle cycles, then present the value
  // and wait for the transfer; start stays high so back-to-back items need no gap.
  task automatic send_value(input logic [b62_pkg::ValueW-1:0] v, input bit calm);
    bit taken;
    while (!calm && $urandom_range(99) < 32) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      if (!busy) begin
        taken = 1'b1;
        sb.note_value(v);
      end
    end
  endtask

  initial begin
    char_t none;
    sb     = new();
    rst    = 1'b1;
    start  = 1'b0;
    value  = '0;
    none   = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_value(64'd0, 1'b0);
    send_value(64'd1, 1'b0);
    send_value(64'd9, 1'b0);
    send_value(64'd10, 1'b0);
    send_value(64'd35, 1'b0);
    send_value(64'd36, 1'b0);
    send_value(64'd61, 1'b0);
    send_value(64'd62, 1'b0);
    send_value(64'd63, 1'b0);
    send_value(64'd3843, 1'b0);
    send_value(64'd3844, 1'b0);
    for (int k = 2; k <= 10; k += 2) begin
      send_value(pow62(k) - 64'd1, 1'b0);
      send_value(pow62(k), 1'b0);
    end
    send_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_value(64'h8000_0000_0000_0000, 1'b0);
    send_value(64'h5555_5555_5555_5555, 1'b0);
    send_value(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_value(random_value(), (i >= 120 && i < 200));
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.pending.size() != 0) begin
      sb.report("characters never emitted", sb.pending[0], none);
    end

    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/b62_pkg.sv
src/b62_div_step.sv
src/base62_number_encoder_core.sv
dv/tb_base62_number_encoder_core.sv
